// ===== hdl/bmf_pkg.sv =====
// ----------------------------------------------------------------------------
// bmf_pkg
// Shared constants and types for the box mean filter.
// ----------------------------------------------------------------------------
package bmf_pkg;

	localparam int MAX_WINDOW   = 5;
	localparam int MAX_WIDTH    = 1024;
	localparam int PIXEL_BITS   = 8;
	localparam int HEIGHT_LIMIT = 1024;

	localparam int VALUE_W   = 8;
	localparam int ROW_OUT_W = 10;
	localparam int COL_OUT_W = 10;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 11;
	localparam int HEIGHT_W  = 11;
	localparam int WINREG_W  = 3;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_IMAGE_WIDTH  = cfg_idx_t'(0);
	localparam cfg_idx_t REG_IMAGE_HEIGHT = cfg_idx_t'(1);
	localparam cfg_idx_t REG_WINDOW_SIZE  = cfg_idx_t'(2);

	localparam logic [CFG_DAT_W-1:0] RST_IMAGE_WIDTH  = CFG_DAT_W'(1024);
	localparam logic [CFG_DAT_W-1:0] RST_IMAGE_HEIGHT = CFG_DAT_W'(1024);
	localparam logic [WINREG_W-1:0]  RST_WINDOW_SIZE  = WINREG_W'(5);

endpackage

// ===== hdl/bmf_if.sv =====
// ----------------------------------------------------------------------------
// bmf_if
// Valid/ready channels of the box mean filter: pixels, results, register writes.
// ----------------------------------------------------------------------------
interface bmf_pix_if;
	logic                          valid;
	logic                          ready;
	logic                          command;
	logic [bmf_pkg::VALUE_W-1:0]   pixel_value;

	modport source (output valid, command, pixel_value, input ready);
	modport sink   (input valid, command, pixel_value, output ready);
endinterface

interface bmf_res_if;
	logic                          valid;
	logic                          ready;
	logic [bmf_pkg::VALUE_W-1:0]   filtered_value;
	logic [bmf_pkg::ROW_OUT_W-1:0] out_row;
	logic [bmf_pkg::COL_OUT_W-1:0] out_col;
	logic                          last_of_frame;

	modport source (output valid, filtered_value, out_row, out_col, last_of_frame,
		input ready);
	modport sink   (input valid, filtered_value, out_row, out_col, last_of_frame,
		output ready);
endinterface

interface bmf_cfg_if;
	logic                          valid;
	logic                          ready;
	bmf_pkg::cfg_idx_t             index;
	logic [bmf_pkg::CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/bmf_ring_ram.sv =====
// ----------------------------------------------------------------------------
// bmf_ring_ram
// Pixel history ring: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bmf_ring_ram #(
	parameter int DEPTH = 4101,
	parameter int AW    = 13,
	parameter int DW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/bmf_div.sv =====
// ----------------------------------------------------------------------------
// bmf_div
// Divide by the window area: reciprocal multiply, quotient the cycle after start.
// ----------------------------------------------------------------------------
module bmf_div #(
	parameter int NUM_W = 13,
	parameter int DEN_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int SHIFT  = NUM_W + DEN_W;
	localparam int RCP_W  = SHIFT + 1;
	localparam int PROD_W = NUM_W + RCP_W;

	logic [RCP_W-1:0]  recip;
	logic [PROD_W-1:0] prod_q;

	always_comb begin
		recip = '0;
		for (int k = 1; k < 2 ** DEN_W; k++) begin
			if (den == DEN_W'(k)) begin
				recip = RCP_W'(((64'd1 << SHIFT) + 64'(k) - 64'd1) / 64'(k));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_q <= PROD_W'(num) * PROD_W'(recip);
		end
	end

	assign quot = prod_q[SHIFT +: NUM_W];

endmodule

// ===== hdl/box_mean_filter.sv =====
// ----------------------------------------------------------------------------
// box_mean_filter
// Zero-padded box mean over a raster-order grey pixel stream.
// ----------------------------------------------------------------------------
// One item is handled at a time. An item that gives no result passes through
// the decide state and back to idle. An item that gives a result passes
// through the decide state, the window read one pixel per cycle through the
// single read port of the history ring, the last read, the start and finish
// of the reciprocal multiply that divides by the window area, loading the
// output register, and idle. Loading the output register waits while it
// still holds a stalled result. A finished result waits in the output
// register while the next item is taken. The ring is not cleared after
// reset. A write to the width, height or window register restarts the frame;
// any register write holds off pixels through the setup state.
// ----------------------------------------------------------------------------
module box_mean_filter #(
	parameter int MAX_WINDOW = bmf_pkg::MAX_WINDOW,
	parameter int MAX_WIDTH  = bmf_pkg::MAX_WIDTH,
	parameter int PIXEL_BITS = bmf_pkg::PIXEL_BITS
) (
	input logic     clk,
	input logic     arst_n,
	bmf_pix_if.sink pix,
	bmf_res_if.source res,
	bmf_cfg_if.sink cfg
);

	localparam int RING   = (MAX_WINDOW - 1) * MAX_WIDTH + MAX_WINDOW;
	localparam int RA_W   = (RING > 1) ? $clog2(RING) : 1;
	localparam int WD_W   = $clog2(MAX_WIDTH + 1);
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(bmf_pkg::HEIGHT_LIMIT);
	localparam int LIN_W  = $clog2(MAX_WIDTH * bmf_pkg::HEIGHT_LIMIT + 1);
	localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
	localparam int AREA_W = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
	localparam int SUM_W  = PIXEL_BITS + AREA_W;
	localparam int OFF_W  = RA_W + 2;
	localparam int ROW_SW = $clog2(bmf_pkg::HEIGHT_LIMIT + MAX_WINDOW) + 1;
	localparam int COL_SW = $clog2(MAX_WIDTH + MAX_WINDOW) + 1;
	localparam int HW     = bmf_pkg::HEIGHT_W;

	typedef enum logic [2:0] {
		ST_SETUP, ST_IDLE, ST_DECIDE, ST_SCAN, ST_TAIL, ST_DIV_GO, ST_DIV_WAIT, ST_PUT
	} state_t;

	state_t state_q;

	logic [bmf_pkg::CFG_DAT_W-1:0] width_q;
	logic [bmf_pkg::CFG_DAT_W-1:0] height_q;
	logic [bmf_pkg::WINREG_W-1:0]  win_q;

	logic [WD_W-1:0]  w_eff;
	logic [HW-1:0]    h_eff;
	logic [WIN_W-1:0] s_eff;
	logic [WIN_W-1:0] half_eff;
	logic [WIN_W-1:0] fwd_eff;

	logic [WD_W-1:0]         w_q;
	logic [HW-1:0]           h_q;
	logic [WIN_W-1:0]        s_q;
	logic [WIN_W-1:0]        half_q;
	logic [LIN_W-1:0]        total_q;
	logic [LIN_W-1:0]        delay_q;
	logic [RA_W-1:0]         back_q;
	logic [AREA_W-1:0]       area_q;
	logic signed [OFF_W-1:0] rowstep_q;

	logic [LIN_W-1:0] rcv_q;
	logic [LIN_W-1:0] e_q;
	logic [ROW_W-1:0] er_q;
	logic [COL_W-1:0] ec_q;
	logic [RA_W-1:0]  ep_q;
	logic [RA_W-1:0]  wr_q;

	logic                       cmd_q;
	logic [bmf_pkg::VALUE_W-1:0] pixv_q;

	logic [WIN_W-1:0]         i_q;
	logic [WIN_W-1:0]         j_q;
	logic signed [ROW_SW-1:0] pr_q;
	logic signed [COL_SW-1:0] pc_q;
	logic signed [COL_SW-1:0] pc0_q;
	logic signed [OFF_W-1:0]  off_q;
	logic                     rd_vld_s1;
	logic [SUM_W-1:0]         sum_q;

	logic                            out_valid_q;
	logic [bmf_pkg::VALUE_W-1:0]     out_value_q;
	logic [bmf_pkg::ROW_OUT_W-1:0]   out_row_q;
	logic [bmf_pkg::COL_OUT_W-1:0]   out_col_q;
	logic                            out_last_q;

	logic                    is_pix;
	logic                    full;
	logic [LIN_W-1:0]        rcv_n;
	logic                    emit;
	logic signed [OFF_W-1:0] a_sum;
	logic [RA_W-1:0]         raddr;
	logic                    inb;
	logic                    last_tap;
	logic                    last_out;
	logic                    put_ok;
	logic                    pix_beat;
	logic                    cfg_beat;
	logic [PIXEL_BITS-1:0]   rd_data;
	logic                    div_done;
	logic [SUM_W-1:0]        div_quot;

	assign pix_beat  = pix.valid && pix.ready;
	assign cfg_beat  = cfg.valid && cfg.ready;
	assign cfg.ready = (state_q == ST_IDLE);
	assign pix.ready = (state_q == ST_IDLE) && !cfg.valid;

	assign res.valid          = out_valid_q;
	assign res.filtered_value = out_value_q;
	assign res.out_row        = out_row_q;
	assign res.out_col        = out_col_q;
	assign res.last_of_frame  = out_last_q;

	always_comb begin
		if (width_q == '0) begin
			w_eff = WD_W'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = WD_W'(MAX_WIDTH);
		end else begin
			w_eff = WD_W'(width_q);
		end
		if (height_q == '0) begin
			h_eff = HW'(1);
		end else if (32'(height_q) > bmf_pkg::HEIGHT_LIMIT) begin
			h_eff = HW'(bmf_pkg::HEIGHT_LIMIT);
		end else begin
			h_eff = HW'(height_q);
		end
		if (win_q == '0) begin
			s_eff = WIN_W'(1);
		end else if (32'(win_q) > MAX_WINDOW) begin
			s_eff = WIN_W'(MAX_WINDOW);
		end else begin
			s_eff = WIN_W'(win_q);
		end
		half_eff = s_eff >> 1;
		fwd_eff  = s_eff - WIN_W'(1) - half_eff;
	end

	always_ff @(posedge clk) begin
		w_q       <= w_eff;
		h_q       <= h_eff;
		s_q       <= s_eff;
		half_q    <= half_eff;
		total_q   <= LIN_W'(w_eff) * LIN_W'(h_eff);
		delay_q   <= LIN_W'(fwd_eff) * (LIN_W'(w_eff) + LIN_W'(1));
		back_q    <= RA_W'(LIN_W'(half_eff) * (LIN_W'(w_eff) + LIN_W'(1)));
		area_q    <= AREA_W'(s_eff) * AREA_W'(s_eff);
		rowstep_q <= OFF_W'(w_eff) - OFF_W'(s_eff) + OFF_W'(1);
	end

	always_comb begin
		full     = (rcv_q >= total_q);
		is_pix   = !cmd_q && !full;
		rcv_n    = rcv_q + LIN_W'(is_pix);
		emit     = (is_pix || full) && (e_q < total_q)
			&& ((rcv_n >= total_q)
			|| ({1'b0, rcv_n} > ({1'b0, e_q} + {1'b0, delay_q})));
		a_sum    = $signed({2'b00, ep_q}) + off_q;
		if (a_sum < 0) begin
			raddr = RA_W'(a_sum + OFF_W'(RING));
		end else if (a_sum >= RING) begin
			raddr = RA_W'(a_sum - OFF_W'(RING));
		end else begin
			raddr = RA_W'(a_sum);
		end
		inb      = !pr_q[ROW_SW-1] && ($unsigned(pr_q) < ROW_SW'(h_q))
			&& !pc_q[COL_SW-1] && ($unsigned(pc_q) < COL_SW'(w_q));
		last_tap = (i_q == s_q - WIN_W'(1)) && (j_q == s_q - WIN_W'(1));
		last_out = (e_q == total_q - LIN_W'(1));
		put_ok   = !out_valid_q || res.ready;
	end

	bmf_ring_ram #(
		.DEPTH (RING),
		.AW    (RA_W),
		.DW    (PIXEL_BITS)
	) u_ring (
		.clk   (clk),
		.we    ((state_q == ST_DECIDE) && is_pix),
		.waddr (wr_q),
		.wdata (PIXEL_BITS'(pixv_q)),
		.raddr (raddr),
		.rdata (rd_data)
	);

	bmf_div #(
		.NUM_W (SUM_W),
		.DEN_W (AREA_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_DIV_GO),
		.num    (sum_q),
		.den    (area_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SETUP;
			width_q     <= bmf_pkg::RST_IMAGE_WIDTH;
			height_q    <= bmf_pkg::RST_IMAGE_HEIGHT;
			win_q       <= bmf_pkg::RST_WINDOW_SIZE;
			rcv_q       <= '0;
			e_q         <= '0;
			er_q        <= '0;
			ec_q        <= '0;
			ep_q        <= '0;
			wr_q        <= '0;
			out_valid_q <= 1'b0;
			rd_vld_s1   <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN) && inb;
			if (out_valid_q && res.ready && (state_q != ST_PUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_SETUP: begin
					state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cfg_beat) begin
						if (cfg.index == bmf_pkg::REG_IMAGE_WIDTH ||
							cfg.index == bmf_pkg::REG_IMAGE_HEIGHT ||
							cfg.index == bmf_pkg::REG_WINDOW_SIZE) begin
							rcv_q <= '0;
							e_q   <= '0;
							er_q  <= '0;
							ec_q  <= '0;
							ep_q  <= '0;
							wr_q  <= '0;
						end
						if (cfg.index == bmf_pkg::REG_IMAGE_WIDTH) begin
							width_q <= cfg.data;
						end
						if (cfg.index == bmf_pkg::REG_IMAGE_HEIGHT) begin
							height_q <= cfg.data;
						end
						if (cfg.index == bmf_pkg::REG_WINDOW_SIZE) begin
							win_q <= cfg.data[bmf_pkg::WINREG_W-1:0];
						end
						state_q <= ST_SETUP;
					end else if (pix_beat) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (is_pix) begin
						rcv_q <= rcv_n;
						wr_q  <= (wr_q == RA_W'(RING - 1)) ? '0 : wr_q + RA_W'(1);
					end
					state_q <= emit ? ST_SCAN : ST_IDLE;
				end
				ST_SCAN: begin
					if (last_tap) begin
						state_q <= ST_TAIL;
					end
				end
				ST_TAIL: begin
					state_q <= ST_DIV_GO;
				end
				ST_DIV_GO: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_done) begin
						state_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					if (put_ok) begin
						out_valid_q <= 1'b1;
						if (last_out) begin
							rcv_q <= '0;
							e_q   <= '0;
							er_q  <= '0;
							ec_q  <= '0;
							ep_q  <= '0;
							wr_q  <= '0;
						end else begin
							e_q  <= e_q + LIN_W'(1);
							ep_q <= (ep_q == RA_W'(RING - 1)) ? '0 : ep_q + RA_W'(1);
							if (WD_W'(ec_q) == w_q - WD_W'(1)) begin
								ec_q <= '0;
								er_q <= er_q + ROW_W'(1);
							end else begin
								ec_q <= ec_q + COL_W'(1);
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pix_beat) begin
			cmd_q  <= pix.command;
			pixv_q <= pix.pixel_value;
		end
		if (rd_vld_s1) begin
			sum_q <= sum_q + SUM_W'(rd_data);
		end
		if (state_q == ST_DECIDE) begin
			sum_q <= '0;
			i_q   <= '0;
			j_q   <= '0;
			pr_q  <= ROW_SW'(er_q) - ROW_SW'(half_q);
			pc_q  <= COL_SW'(ec_q) - COL_SW'(half_q);
			pc0_q <= COL_SW'(ec_q) - COL_SW'(half_q);
			off_q <= OFF_W'(0) - OFF_W'(back_q);
		end else if (state_q == ST_SCAN) begin
			if (j_q == s_q - WIN_W'(1)) begin
				j_q   <= '0;
				i_q   <= i_q + WIN_W'(1);
				pr_q  <= pr_q + ROW_SW'(1);
				pc_q  <= pc0_q;
				off_q <= off_q + rowstep_q;
			end else begin
				j_q   <= j_q + WIN_W'(1);
				pc_q  <= pc_q + COL_SW'(1);
				off_q <= off_q + OFF_W'(1);
			end
		end
		if ((state_q == ST_PUT) && put_ok) begin
			out_value_q <= bmf_pkg::VALUE_W'(div_quot);
			out_row_q   <= bmf_pkg::ROW_OUT_W'(er_q);
			out_col_q   <= bmf_pkg::COL_OUT_W'(ec_q);
			out_last_q  <= last_out;
		end
	end

endmodule

// ===== hdl/bmf_checker.sv =====
// ----------------------------------------------------------------------------
// bmf_checker
// Port-level checks of the box mean filter, bound to the top level.
// ----------------------------------------------------------------------------
module bmf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          pix_valid,
	input logic                          pix_ready,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic [bmf_pkg::VALUE_W-1:0]   res_value,
	input logic [bmf_pkg::ROW_OUT_W-1:0] res_row,
	input logic [bmf_pkg::COL_OUT_W-1:0] res_col,
	input logic                          res_last
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result beat dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_value) && $stable(res_row)
			&& $stable(res_col) && $stable(res_last))
		else $error("result payload changed while stalled");

	a_pix_one: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready |=> !pix_ready)
		else $error("pixel taken while previous one in work");

	a_cfg_gap: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !pix_ready)
		else $error("pixel taken right after register write");

endmodule

bind box_mean_filter bmf_checker u_bmf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_valid (pix.valid),
	.pix_ready (pix.ready),
	.cfg_valid (cfg.valid),
	.cfg_ready (cfg.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_value (res.filtered_value),
	.res_row   (res.out_row),
	.res_col   (res.out_col),
	.res_last  (res.last_of_frame)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Box mean filter check: fixed and random frames of pixels and drains go in,
// each result is compared with a software window mean kept in this bench.
// ----------------------------------------------------------------------------
class mean_board;
	int unsigned frame_w, frame_h, win;
	int unsigned in_r, in_c, em_r, em_c;
	int unsigned hist [int unsigned];
	bit [28:0] pending [$];
	int unsigned errors, checked;

	function new();
		frame_w = 1024; frame_h = 1024; win = 5;
		errors = 0; checked = 0;
		restart();
	endfunction

	function void restart();
		in_r = 0; in_c = 0; em_r = 0; em_c = 0;
	endfunction

	function void write_reg(bmf_pkg::cfg_idx_t idx, int unsigned v);
		if (idx == bmf_pkg::REG_IMAGE_WIDTH) frame_w = (v == 0) ? 1 : (v > 1024 ? 1024 : v);
		else if (idx == bmf_pkg::REG_IMAGE_HEIGHT) frame_h = (v == 0) ? 1 : (v > 1024 ? 1024 : v);
		else if (idx == bmf_pkg::REG_WINDOW_SIZE) win = (v == 0) ? 1 : (v > 5 ? 5 : v);
		else return;
		restart();
	endfunction

	function bit full_frame();
		return in_r >= frame_h;
	endfunction

	function void note_beat(bit drain, bit [7:0] px);
		int unsigned fwd, dly, total, got, nxt, sum, pr, pc;
		int half;
		bit last;
		fwd = win - 1 - win / 2;
		dly = fwd * frame_w + fwd;
		total = frame_w * frame_h;
		if (!drain && !full_frame()) begin
			hist[in_r * frame_w + in_c] = 32'(px);
			in_c++;
			if (in_c >= frame_w) begin
				in_c = 0; in_r++;
			end
		end else if (!full_frame()) begin
			return;
		end
		got = full_frame() ? total : in_r * frame_w + in_c;
		nxt = em_r * frame_w + em_c;
		if (nxt >= total) return;
		if (got < total && got <= nxt + dly) return;
		half = win / 2;
		sum = 0;
		for (int i = 0; i < win; i++) begin
			for (int j = 0; j < win; j++) begin
				if (int'(em_r) - half + i < 0 || int'(em_r) - half + i >= int'(frame_h)) continue;
				if (int'(em_c) - half + j < 0 || int'(em_c) - half + j >= int'(frame_w)) continue;
				pr = em_r - half + i;
				pc = em_c - half + j;
				sum += hist[pr * frame_w + pc];
			end
		end
		last = (nxt == total - 1);
		pending.push_back({8'(sum / (win * win)), 10'(em_r), 10'(em_c), last});
		if (last) begin
			restart();
		end else begin
			em_c++;
			if (em_c >= frame_w) begin
				em_c = 0; em_r++;
			end
		end
	endfunction

	function void check_beat(bit [28:0] got);
		bit [28:0] want;
		checked++;
		if (pending.size() == 0) begin
			errors++;
			$display("%0t: unexpected result %h", $time, got);
			return;
		end
		want = pending.pop_front();
		if (want[28:21] != got[28:21] || want[20:11] != got[20:11] ||
				want[10:1] != got[10:1] || want[0] != got[0]) begin
			errors++;
			$display("%0t: expected val %0d row %0d col %0d last %0d, got %0d %0d %0d %0d",
				$time, want[28:21], want[20:11], want[10:1], want[0],
				got[28:21], got[20:11], got[10:1], got[0]);
		end
	endfunction
endclass

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 0;
	logic arst_n = 0;
	longint unsigned cycles = 0;
	int unsigned pix_count = 0, frames = 0;
	mean_board board = new();

	bmf_pix_if pix();
	bmf_res_if res();
	bmf_cfg_if cfg();

	box_mean_filter dut (.clk(clk), .arst_n(arst_n), .pix(pix), .res(res), .cfg(cfg));

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	initial begin
		pix.valid = 0; pix.command = 0; pix.pixel_value = 0;
		cfg.valid = 0; cfg.index = bmf_pkg::REG_IMAGE_WIDTH; cfg.data = 0;
		res.ready = 0;
	end

	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
		if (arst_n && res.valid && res.ready)
			board.check_beat({res.filtered_value, res.out_row, res.out_col, res.last_of_frame});
	end

	bit calm = 0;
	initial begin
		int unsigned g;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (calm) begin
				res.ready <= 1;
			end else begin
				g = gap_len();
				if (g == 0) res.ready <= 1;
				else begin
					res.ready <= 0;
					repeat (g - 1) @(negedge clk);
				end
			end
		end
	end

	task automatic send_beat(bit drain, bit [7:0] px, bit gaps);
		int unsigned g;
		g = gaps ? gap_len() : 0;
		@(negedge clk);
		repeat (g) @(negedge clk);
		pix.valid <= 1; pix.command <= drain; pix.pixel_value <= px;
		@(posedge clk);
		while (!pix.ready) @(posedge clk);
		board.note_beat(drain, px);
		if (!drain) pix_count++;
		@(negedge clk);
		pix.valid <= 0;
	endtask

	task automatic wait_idle();
		while (board.pending.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_reg(bmf_pkg::cfg_idx_t idx, logic [10:0] v);
		@(negedge clk);
		cfg.valid <= 1; cfg.index <= idx; cfg.data <= v;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		board.write_reg(idx, 32'(v));
		@(negedge clk);
		cfg.valid <= 0;
	endtask

	task automatic set_shape(int unsigned w, int unsigned h, int unsigned s);
		wait_idle();
		write_reg(bmf_pkg::REG_IMAGE_WIDTH, 11'(w));
		write_reg(bmf_pkg::REG_IMAGE_HEIGHT, 11'(h));
		write_reg(bmf_pkg::REG_WINDOW_SIZE, 11'(s));
	endtask

	// whole frame with drains until the last result
	task automatic run_frame(int unsigned mode, bit gaps);
		int unsigned n;
		bit [7:0] px;
		n = board.frame_w * board.frame_h;
		for (int unsigned k = 0; k < n; k++) begin
			case (mode)
				0: px = 8'($urandom);
				1: px = 8'hFF;
				2: px = 8'h00;
				default: px = (k % 2) ? 8'hAA : 8'h55;
			endcase
			if ($urandom_range(0, 19) == 0) send_beat(1, 8'($urandom), gaps);
			send_beat(0, px, gaps);
		end
		if ($urandom_range(0, 3) == 0) send_beat(0, 8'($urandom), gaps);
		while (board.full_frame()) send_beat(1, 8'($urandom), gaps);
		frames++;
	endtask

	// start of a frame only; the next register write cuts it off
	task automatic run_part(int unsigned n, bit gaps);
		for (int unsigned k = 0; k < n; k++) begin
			send_beat(0, 8'($urandom), gaps);
		end
	endtask

	initial begin
		int unsigned w, h, s;
		repeat (9) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		send_beat(1, 8'hFF, 0);
		set_shape(3, 3, 5); run_frame(1, 0);
		set_shape(1, 1, 1); run_frame(1, 0);
		set_shape(1, 4, 3); run_frame(3, 0);
		set_shape(4, 1, 4); run_frame(2, 0);
		set_shape(0, 0, 0); run_frame(1, 0);
		set_shape(3, 2, 7); run_frame(0, 0);
		set_shape(5, 2, 2); run_frame(3, 0);
		calm = 1;
		set_shape(1100, 1, 2); run_part(120, 0);
		set_shape(1, 1030, 3); run_part(120, 0);
		calm = 0;
		set_shape(1024, 2, 2); run_part(150, 1);
		while (pix_count < 720) begin
			w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 9);
			h = $urandom_range(1, 8);
			s = $urandom_range(0, 7);
			set_shape(w, h, s);
			run_frame(0, 1);
			if ($urandom_range(0, 5) == 0) wait_idle();
		end
		wait_idle();
		$display("Ran %0d frames, %0d pixels, %0d results checked.",
			frames, pix_count, board.checked);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
